// ===== rtl/mpsu_pkg.sv =====
// shared types and constants for the mips prologue stack unwinder
// no dependencies; imported by mpsu_front, mpsu_back and the top level

package mpsu_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned REG_W    = 5;
  localparam int unsigned NUM_REGS = 32;

  // instruction patterns
  localparam logic [WORD_W-1:0] ADDIU_SP_MASK  = 32'hFFFF_0000;
  localparam logic [WORD_W-1:0] ADDIU_SP_MATCH = 32'h27BD_0000;
  localparam logic [WORD_W-1:0] SW_SP_MASK     = 32'hFFE0_0000;
  localparam logic [WORD_W-1:0] SW_SP_MATCH    = 32'hAFA0_0000;
  localparam logic [WORD_W-1:0] JR_RA_WORD     = 32'h03E0_0008;
  localparam logic [REG_W-1:0]  REG_RA         = 5'h1F;

  // queue depths
  localparam int unsigned MID_DEPTH_DEF = 2;
  localparam int unsigned OUT_DEPTH_DEF = 2;

  // request kinds
  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_WORD  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // instruction classes
  typedef enum logic [2:0] {
    OP_OTHER,
    OP_ADDIU_ADJ,
    OP_ADDIU_POS,
    OP_SW,
    OP_JR_RA
  } op_t;

  // classified request between front and back
  typedef struct packed {
    req_t              kind;
    op_t               op;
    logic [WORD_W-1:0] value;   // initial sp, or signed offset to add to sp
    logic [REG_W-1:0]  reg_sel;
    logic              last;
  } mid_item_t;

  // result record
  typedef struct packed {
    logic              scan_done;
    logic              unwind_ok;
    logic [WORD_W-1:0] frame_sp;
    logic [WORD_W-1:0] slot_address;
    logic              slot_written;
  } result_t;

endpackage

// ===== rtl/mpsu_fifo.sv =====
// small synchronous queue with full and empty flags decoded from a registered fill count
// no dependencies; used between front and back and on the result side

module mpsu_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rd_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/mpsu_front.sv =====
// front end: takes requests and classifies instruction words
// depends on mpsu_pkg

module mpsu_front import mpsu_pkg::*; (
  input  logic              push,
  output logic              full,
  input  logic [1:0]        req_type,
  input  logic [WORD_W-1:0] initial_sp,
  input  logic [WORD_W-1:0] instr_word,
  input  logic              last_word,
  input  logic [REG_W-1:0]  reg_index,
  input  logic              mid_full,
  output logic              mid_push,
  output mid_item_t         mid_item
);

  logic [WORD_W-1:0] imm_rnd;
  logic              imm_pos;

  assign full     = mid_full;
  assign mid_push = push;

  // sign-extended immediate rounded down to a word multiple
  assign imm_rnd = {{(WORD_W-16){instr_word[15]}}, instr_word[15:2], 2'b00};
  assign imm_pos = (instr_word[15:0] != 16'h0000) && !instr_word[15];

  // classify the request
  always_comb begin
    mid_item.kind    = req_t'(req_type);
    mid_item.op      = OP_OTHER;
    mid_item.value   = '0;
    mid_item.reg_sel = reg_index;
    mid_item.last    = last_word;
    case (req_t'(req_type))
      REQ_START: begin
        mid_item.value = initial_sp;
      end
      REQ_WORD: begin
        mid_item.reg_sel = instr_word[20:16];
        if ((instr_word & ADDIU_SP_MASK) == ADDIU_SP_MATCH) begin
          // frame adjust: the back end adds the negated immediate
          mid_item.op    = imm_pos ? OP_ADDIU_POS : OP_ADDIU_ADJ;
          mid_item.value = '0 - imm_rnd;
        end else if ((instr_word & SW_SP_MASK) == SW_SP_MATCH) begin
          mid_item.op    = OP_SW;
          mid_item.value = imm_rnd;
        end else if (instr_word == JR_RA_WORD) begin
          mid_item.op = OP_JR_RA;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/mpsu_back.sv =====
// back end: holds the scan state and saved slots, builds one result per request
// depends on mpsu_pkg

module mpsu_back import mpsu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_empty,
  input  mid_item_t in_item,
  output logic      in_pop,
  input  logic      out_full,
  output logic      out_push,
  output result_t   out_item
);

  logic [WORD_W-1:0]   cur_sp;
  logic [WORD_W-1:0]   cur_sp_next;
  logic                sp_seen;
  logic                sp_seen_next;
  logic                ra_seen;
  logic                ra_seen_next;
  logic                halted;
  logic                halted_next;
  logic [NUM_REGS-1:0] slot_valid;
  logic [NUM_REGS-1:0] slot_valid_next;
  logic [WORD_W-1:0]   slot_store [NUM_REGS];
  logic                slot_we;
  logic [WORD_W-1:0]   sp_sum;
  logic                stop;
  logic                fire;
  logic                ok;

  assign fire     = !in_empty && !out_full;
  assign in_pop   = fire;
  assign out_push = fire;
  assign sp_sum   = cur_sp + in_item.value;

  // state update for the request at the head of the queue
  always_comb begin
    cur_sp_next     = cur_sp;
    sp_seen_next    = sp_seen;
    ra_seen_next    = ra_seen;
    halted_next     = halted;
    slot_valid_next = slot_valid;
    slot_we         = 1'b0;
    stop            = 1'b0;
    case (in_item.kind)
      REQ_START: begin
        cur_sp_next     = in_item.value;
        sp_seen_next    = 1'b0;
        ra_seen_next    = 1'b0;
        slot_valid_next = '0;
        halted_next     = 1'b0;
      end
      REQ_WORD: begin
        if (!halted) begin
          case (in_item.op)
            OP_ADDIU_POS: begin
              sp_seen_next = 1'b1;
              stop         = 1'b1;
            end
            OP_ADDIU_ADJ: begin
              sp_seen_next = 1'b1;
              cur_sp_next  = sp_sum;
              stop         = ra_seen;
            end
            OP_SW: begin
              slot_we                          = 1'b1;
              slot_valid_next[in_item.reg_sel] = 1'b1;
              if (in_item.reg_sel == REG_RA) begin
                ra_seen_next = 1'b1;
              end
              stop = sp_seen && ((in_item.reg_sel == REG_RA) || ra_seen);
            end
            OP_JR_RA: begin
              stop = 1'b1;
            end
            default: begin
            end
          endcase
          if (stop || in_item.last) begin
            halted_next = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result record
  always_comb begin
    ok                    = sp_seen_next && ra_seen_next;
    out_item.scan_done    = halted_next;
    out_item.unwind_ok    = ok;
    out_item.frame_sp     = ok ? cur_sp_next : '0;
    out_item.slot_address = '0;
    out_item.slot_written = 1'b0;
    if ((in_item.kind == REQ_READ) && slot_valid[in_item.reg_sel]) begin
      out_item.slot_address = slot_store[in_item.reg_sel];
      out_item.slot_written = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_sp     <= '0;
      sp_seen    <= 1'b0;
      ra_seen    <= 1'b0;
      halted     <= 1'b1;
      slot_valid <= '0;
    end else if (fire) begin
      cur_sp     <= cur_sp_next;
      sp_seen    <= sp_seen_next;
      ra_seen    <= ra_seen_next;
      halted     <= halted_next;
      slot_valid <= slot_valid_next;
    end
  end

  // saved slot addresses, read only through slot_valid
  always_ff @(posedge clk) begin
    if (fire && slot_we) begin
      slot_store[in_item.reg_sel] <= sp_sum;
    end
  end

endmodule

// ===== rtl/mips_prologue_stack_unwinder_core.sv =====
// top level of the mips prologue stack unwinder
// depends on mpsu_pkg, mpsu_front, mpsu_back, mpsu_fifo
//
//   channel  | direction | handshake    | payload
//   ---------+-----------+--------------+-------------------------------------------
//   request  | in        | push / full  | req_type initial_sp instr_word last_word
//            |           |              | reg_index
//   result   | out       | pop / empty  | scan_done unwind_ok frame_sp slot_address
//            |           |              | slot_written
//
// one request per cycle sustained while the result side drains; a request is held in the
// front queue, then the back end adds and pushes its result into the result queue.
// reset clears both queues and the scan state; no scan is active after reset.
// a stalled result side fills the result queue, then the front queue, then raises full.

module mips_prologue_stack_unwinder_core import mpsu_pkg::*; #(
  parameter int unsigned MID_DEPTH = MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        req_type,
  input  logic [WORD_W-1:0] initial_sp,
  input  logic [WORD_W-1:0] instr_word,
  input  logic              last_word,
  input  logic [REG_W-1:0]  reg_index,
  input  logic              pop,
  output logic              empty,
  output logic              scan_done,
  output logic              unwind_ok,
  output logic [WORD_W-1:0] frame_sp,
  output logic [WORD_W-1:0] slot_address,
  output logic              slot_written
);

  localparam int unsigned MID_W = $bits(mid_item_t);
  localparam int unsigned OUT_W = $bits(result_t);

  logic      mid_push;
  logic      mid_full;
  mid_item_t mid_wr;
  logic      mid_pop;
  logic      mid_empty;
  mid_item_t mid_rd;
  logic      res_push;
  logic      res_full;
  result_t   res_wr;
  result_t   res_rd;

  // request classification
  mpsu_front u_front (
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .initial_sp (initial_sp),
    .instr_word (instr_word),
    .last_word  (last_word),
    .reg_index  (reg_index),
    .mid_full   (mid_full),
    .mid_push   (mid_push),
    .mid_item   (mid_wr)
  );

  // queue between front and back
  mpsu_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (mid_push),
    .full    (mid_full),
    .wr_data (mid_wr),
    .pop     (mid_pop),
    .empty   (mid_empty),
    .rd_data (mid_rd)
  );

  // scan state and slot lookup
  mpsu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_empty (mid_empty),
    .in_item  (mid_rd),
    .in_pop   (mid_pop),
    .out_full (res_full),
    .out_push (res_push),
    .out_item (res_wr)
  );

  // result queue
  mpsu_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_res_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .full    (res_full),
    .wr_data (res_wr),
    .pop     (pop),
    .empty   (empty),
    .rd_data (res_rd)
  );

  assign scan_done    = res_rd.scan_done;
  assign unwind_ok    = res_rd.unwind_ok;
  assign frame_sp     = res_rd.frame_sp;
  assign slot_address = res_rd.slot_address;
  assign slot_written = res_rd.slot_written;

endmodule
